// ===== design/srsw_pkg.sv =====
package srsw_pkg;

  // default sizes
  localparam int DEF_SLOTS       = 8;
  localparam int DEF_MAX_SEGMENT = 500;

  // register reset values
  localparam logic [15:0] RST_WINDOW_BYTES  = 16'd2500;
  localparam logic [15:0] RST_SEQ_LIMIT     = 16'd60000;
  localparam logic [14:0] RST_TIMEOUT_TICKS = 15'd500;

  // configuration register indexes
  localparam logic [1:0] CFG_WINDOW_BYTES  = 2'd0;
  localparam logic [1:0] CFG_SEQ_LIMIT     = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

  // input opcodes
  localparam logic [1:0] OP_OFFER = 2'd0;
  localparam logic [1:0] OP_ACK   = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_NEW     = 2'd0;
  localparam logic [1:0] KIND_RESEND  = 2'd1;
  localparam logic [1:0] KIND_REFUSED = 2'd2;
  localparam logic [1:0] KIND_STATUS  = 2'd3;

  // one in-flight segment
  typedef struct packed {
    logic [15:0] seq;
    logic [8:0]  len;
    logic        first;
    logic        fin;
    logic        acked;
    logic [15:0] sent;
  } slot_t;

  // per-cell control
  typedef struct packed {
    logic rot;
    logic load;
  } cell_ctl_t;

endpackage

// ===== design/srsw_cell.sv =====
module srsw_cell
  import srsw_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  slot_t     nbr,
  input  slot_t     new_slot,
  output slot_t     q
);

  slot_t slot;

  // take the neighbour's segment on a rotation, or a fresh one on a load
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      slot <= new_slot;
    end else if (ctl.rot) begin
      slot <= nbr;
    end
  end

  assign q = slot;

endmodule

// ===== design/selective_repeat_sender_window.sv =====
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | opcode, seg_length, seg_first, seg_last, ack_seq
// out     | output    | out_valid / out_ready | kind, seq, length, first_flag, end_flag,
//         |           |                       | acked_point, transfer_done, last
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// an offer or an unused opcode passes S_PREP, then S_OFFER or S_STATUS, whose result is registered
// an ack rotates the segment row once fully past the head cell in S_ACKSCAN, then r more
// times in S_RETIRE, r being the number of segments retired
// a tick with segments outstanding rotates the row once past the head cell in S_TICKSCN;
// with nothing outstanding it goes from S_PREP straight to S_STATUS
// a stalled output holds the rotation while a resend waits; cfg_ready is always high
// synchronous reset empties the row at once by clearing the fill count
module selective_repeat_sender_window
  import srsw_pkg::*;
#(
  parameter int SLOTS       = DEF_SLOTS,
  parameter int MAX_SEGMENT = DEF_MAX_SEGMENT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [8:0]  seg_length,
  input  logic        seg_first,
  input  logic        seg_last,
  input  logic [15:0] ack_seq,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [15:0] seq,
  output logic [8:0]  length,
  output logic        first_flag,
  output logic        end_flag,
  output logic [15:0] acked_point,
  output logic        transfer_done,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
  localparam logic [CW-1:0] STEP_END = CW'(SLOTS - 1);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_PREP    = 7'b0000010,
    S_OFFER   = 7'b0000100,
    S_ACKSCAN = 7'b0001000,
    S_RETIRE  = 7'b0010000,
    S_TICKSCN = 7'b0100000,
    S_STATUS  = 7'b1000000
  } state_t;

  state_t state;

  // configuration registers
  logic [15:0] window_bytes;
  logic [15:0] seq_limit;
  logic [14:0] timeout_ticks;

  // window state
  logic [15:0] next_seq;
  logic [15:0] acked_upto;
  logic        end_sent;
  logic [CW-1:0] count;
  logic [15:0] tick_count;

  // scan state
  logic [CW-1:0] step;
  logic [CW-1:0] retire_n;
  logic [CW-1:0] retire_n_next;
  logic          found;
  logic          prefix;
  logic [15:0]   ack_cand;
  logic [15:0]   ack_cand_next;

  // latched input transaction
  logic [1:0]  op_r;
  logic [8:0]  len_r;
  logic        first_r;
  logic        last_r;
  logic [15:0] aseq_r;

  // segment row
  slot_t     cell_q [SLOTS];
  slot_t     head;
  slot_t     head_mod;
  slot_t     new_slot;
  logic      rot;
  logic      in_scope;
  logic      match;
  logic      acked_new;
  logic      need_tx;
  logic [15:0] age;

  // emission
  logic        out_free;
  logic        emit;
  logic [1:0]  e_kind;
  logic [15:0] e_seq;
  logic [8:0]  e_len;
  logic        e_first;
  logic        e_end;
  logic [15:0] e_acked;
  logic        e_done;
  logic        e_last;

  // offer checks and restart
  logic        offer_ok;
  logic [15:0] offer_next;
  logic        restart;
  logic [8:0]  len_clamped;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  assign head = cell_q[0];
  assign new_slot = '{seq: next_seq, len: len_r, first: first_r, fin: last_r,
                      acked: 1'b0, sent: tick_count};

  // clamp oversized offers
  assign len_clamped = ({3'b000, seg_length} > 12'(MAX_SEGMENT)) ? 9'(MAX_SEGMENT) : seg_length;

  assign restart = (acked_upto == next_seq) && (next_seq >= seq_limit);

  assign offer_next = next_seq + 16'(len_r);
  assign offer_ok = !end_sent && (acked_upto <= next_seq)
                 && ({1'b0, next_seq} < ({1'b0, acked_upto} + {1'b0, window_bytes}))
                 && (next_seq < seq_limit) && (count < SLOTS_C)
                 && (({1'b0, next_seq} + 17'(len_r)) <= 17'h0FFFF);

  // head cell evaluation
  always_comb begin
    in_scope  = (step < count);
    match     = in_scope && !found && (head.seq == aseq_r);
    acked_new = head.acked || match;
    age       = tick_count - head.sent;
    need_tx   = in_scope && !head.acked && (age > {1'b0, timeout_ticks});
    head_mod  = head;
    rot       = 1'b0;
    retire_n_next = retire_n;
    ack_cand_next = ack_cand;
    case (state)
      S_ACKSCAN: begin
        rot = 1'b1;
        head_mod.acked = acked_new;
        if (in_scope && prefix && acked_new) begin
          retire_n_next = retire_n + CW'(1);
          ack_cand_next = head.seq + 16'(head.len);
        end
      end
      S_RETIRE: begin
        rot = 1'b1;
      end
      S_TICKSCN: begin
        rot = !need_tx || out_free;
        if (need_tx) begin
          head_mod.sent = tick_count;
        end
      end
      default: begin
        rot = 1'b0;
      end
    endcase
  end

  // row of cells, each handing its segment to the one before it
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    cell_ctl_t ctl;
    slot_t     nbr;
    assign ctl.rot  = rot;
    assign ctl.load = (state == S_OFFER) && out_free && offer_ok && (count == CW'(i));
    if (i == SLOTS - 1) begin : g_tail
      assign nbr = head_mod;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end
    srsw_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .nbr      (nbr),
      .new_slot (new_slot),
      .q        (cell_q[i])
    );
  end

  // result selection
  always_comb begin
    emit    = 1'b0;
    e_kind  = KIND_STATUS;
    e_seq   = next_seq;
    e_len   = '0;
    e_first = 1'b0;
    e_end   = 1'b0;
    e_acked = acked_upto;
    e_done  = end_sent && (acked_upto == next_seq);
    e_last  = 1'b1;
    case (state)
      S_OFFER: begin
        emit = out_free;
        if (offer_ok) begin
          e_kind  = KIND_NEW;
          e_len   = len_r;
          e_first = first_r;
          e_end   = last_r;
          e_done  = (end_sent || last_r) && (acked_upto == offer_next);
        end else begin
          e_kind = KIND_REFUSED;
        end
      end
      S_TICKSCN: begin
        emit    = need_tx && out_free;
        e_kind  = KIND_RESEND;
        e_seq   = head.seq;
        e_len   = head.len;
        e_first = head.first;
        e_end   = head.fin;
        e_last  = 1'b0;
      end
      S_STATUS: begin
        emit = out_free;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind          <= e_kind;
      seq           <= e_seq;
      length        <= e_len;
      first_flag    <= e_first;
      end_flag      <= e_end;
      acked_point   <= e_acked;
      transfer_done <= e_done;
      last          <= e_last;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_bytes  <= RST_WINDOW_BYTES;
      seq_limit     <= RST_SEQ_LIMIT;
      timeout_ticks <= RST_TIMEOUT_TICKS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WINDOW_BYTES:  window_bytes  <= cfg_data;
        CFG_SEQ_LIMIT:     seq_limit     <= cfg_data;
        CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r    <= opcode;
      len_r   <= len_clamped;
      first_r <= seg_first;
      last_r  <= seg_last;
      aseq_r  <= ack_seq;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      next_seq   <= '0;
      acked_upto <= '0;
      end_sent   <= 1'b0;
      count      <= '0;
      tick_count <= '0;
      step       <= '0;
      retire_n   <= '0;
      found      <= 1'b0;
      prefix     <= 1'b0;
      ack_cand   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          // restart numbering once all is acknowledged past the limit
          if (restart) begin
            next_seq   <= '0;
            acked_upto <= '0;
            count      <= '0;
          end
          step     <= '0;
          retire_n <= '0;
          found    <= 1'b0;
          prefix   <= 1'b1;
          case (op_r)
            OP_OFFER: state <= S_OFFER;
            OP_ACK:   state <= S_ACKSCAN;
            OP_TICK: begin
              tick_count <= tick_count + 16'd1;
              state <= (!restart && (acked_upto < next_seq)) ? S_TICKSCN : S_STATUS;
            end
            default:  state <= S_STATUS;
          endcase
        end
        S_OFFER: begin
          if (out_free) begin
            if (offer_ok) begin
              count    <= count + CW'(1);
              next_seq <= offer_next;
              if (last_r) begin
                end_sent <= 1'b1;
              end
            end
            state <= S_IDLE;
          end
        end
        S_ACKSCAN: begin
          if (match) begin
            found <= 1'b1;
          end
          if (in_scope && !(prefix && acked_new)) begin
            prefix <= 1'b0;
          end
          retire_n <= retire_n_next;
          ack_cand <= ack_cand_next;
          step     <= step + CW'(1);
          if (step == STEP_END) begin
            count <= count - retire_n_next;
            if (retire_n_next != '0) begin
              acked_upto <= ack_cand_next;
              state      <= S_RETIRE;
            end else begin
              state <= S_STATUS;
            end
          end
        end
        S_RETIRE: begin
          // extra rotations drop the retired prefix off the head
          retire_n <= retire_n - CW'(1);
          if (retire_n == CW'(1)) begin
            state <= S_STATUS;
          end
        end
        S_TICKSCN: begin
          if (rot) begin
            step <= step + CW'(1);
            if (step == STEP_END) begin
              state <= S_STATUS;
            end
          end
        end
        S_STATUS: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // fill count stays within the row
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= SLOTS_C)
    else $error("fill count above slot count");

  // the acknowledged point never passes the next number between transactions
  a_acked_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (acked_upto <= next_seq))
    else $error("acked point beyond next sequence number");

  // a resend is never the closing result of a transaction
  a_resend_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_RESEND) |-> !last)
    else $error("resend marked as last");

  // an accepted input transaction starts work at once
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_PREP))
    else $error("accepted transaction not started");

  // the retire pass only runs with segments still to drop
  a_retire_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_RETIRE) |-> (retire_n != '0))
    else $error("retire pass with nothing to retire");

endmodule

// ===== tb/window_tracker.sv =====
`timescale 1ns / 1ps

module window_tracker
  import srsw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [8:0]  seg_length,
  input  logic        seg_first,
  input  logic        seg_last,
  input  logic [15:0] ack_seq,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  kind,
  input  logic [15:0] seq,
  input  logic [8:0]  length,
  input  logic        first_flag,
  input  logic        end_flag,
  input  logic [15:0] acked_point,
  input  logic        transfer_done,
  input  logic        last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          pending
);

  localparam int unsigned RING    = DEF_SLOTS;
  localparam int unsigned SEG_MAX = DEF_MAX_SEGMENT;

  // one header as it leaves the block
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] seq;
    logic [8:0]  length;
    logic        first_flag;
    logic        end_flag;
    logic [15:0] acked_point;
    logic        transfer_done;
    logic        last;
  } header_t;

  header_t     headers_due[$];
  slot_t       seg_ring[RING];
  int unsigned win_bytes, stop_seq, resend_age;
  int unsigned nxt_pt, acked_pt, ticks, head, fill;
  logic        fin_sent;
  int          bad = 0;

  // header as the block would build it from the current window
  task automatic queue_header(input logic [1:0] k, input logic [15:0] s, input logic [8:0] n,
                              input logic f, input logic e, input logic lst);
    header_t h;
    h.kind          = k;
    h.seq           = s;
    h.length        = n;
    h.first_flag    = f;
    h.end_flag      = e;
    h.acked_point   = acked_pt[15:0];
    h.transfer_done = fin_sent && (acked_pt == nxt_pt);
    h.last          = lst;
    headers_due.push_back(h);
  endtask

  // one accepted transaction applied to the sender window
  task automatic advance_window(input logic [1:0] op, input logic [8:0] raw_len,
                                input logic f, input logic l, input logic [15:0] aseq);
    int unsigned seg_len, i, idx, age;
    bit          ok, hit;
    // numbering restarts once everything up to the limit is acknowledged
    if (acked_pt == nxt_pt && nxt_pt >= stop_seq) begin
      nxt_pt   = 0;
      acked_pt = 0;
      head     = 0;
      fill     = 0;
    end
    case (op)
      OP_OFFER: begin
        seg_len = (32'(raw_len) > SEG_MAX) ? SEG_MAX : 32'(raw_len);
        ok = !fin_sent && acked_pt <= nxt_pt && nxt_pt < acked_pt + win_bytes &&
             nxt_pt < stop_seq && fill < RING && nxt_pt + seg_len <= 32'hFFFF;
        if (ok) begin
          idx = (head + fill) % RING;
          seg_ring[idx] = '{seq: nxt_pt[15:0], len: seg_len[8:0], first: f, fin: l,
                            acked: 1'b0, sent: ticks[15:0]};
          fill++;
          nxt_pt += seg_len;
          if (l) fin_sent = 1'b1;
          queue_header(KIND_NEW, seg_ring[idx].seq, seg_len[8:0], f, l, 1'b1);
        end else begin
          queue_header(KIND_REFUSED, nxt_pt[15:0], 9'd0, 1'b0, 1'b0, 1'b1);
        end
      end
      OP_ACK: begin
        // mark the oldest match, then retire the acknowledged prefix
        hit = 1'b0;
        for (i = 0; i < fill && !hit; i++) begin
          idx = (head + i) % RING;
          if (seg_ring[idx].seq == aseq) begin
            seg_ring[idx].acked = 1'b1;
            hit = 1'b1;
          end
        end
        while (fill > 0 && seg_ring[head].acked) begin
          acked_pt = 32'(seg_ring[head].seq) + 32'(seg_ring[head].len);
          head     = (head + 1) % RING;
          fill--;
        end
        queue_header(KIND_STATUS, nxt_pt[15:0], 9'd0, 1'b0, 1'b0, 1'b1);
      end
      OP_TICK: begin
        ticks = (ticks + 1) & 32'hFFFF;
        if (acked_pt < nxt_pt) begin
          for (i = 0; i < fill; i++) begin
            idx = (head + i) % RING;
            age = (ticks - 32'(seg_ring[idx].sent)) & 32'hFFFF;
            if (!seg_ring[idx].acked && age > resend_age) begin
              seg_ring[idx].sent = ticks[15:0];
              queue_header(KIND_RESEND, seg_ring[idx].seq, seg_ring[idx].len,
                           seg_ring[idx].first, seg_ring[idx].fin, 1'b0);
            end
          end
        end
        queue_header(KIND_STATUS, nxt_pt[15:0], 9'd0, 1'b0, 1'b0, 1'b1);
      end
      default: begin
        queue_header(KIND_STATUS, nxt_pt[15:0], 9'd0, 1'b0, 1'b0, 1'b1);
      end
    endcase
  endtask

  // watch the three channels at every edge
  always @(posedge clk) begin : track
    header_t got, want;
    if (rst) begin
      win_bytes  = 32'(RST_WINDOW_BYTES);
      stop_seq   = 32'(RST_SEQ_LIMIT);
      resend_age = 32'(RST_TIMEOUT_TICKS);
      nxt_pt     = 0;
      acked_pt   = 0;
      ticks      = 0;
      head       = 0;
      fill       = 0;
      fin_sent   = 1'b0;
      headers_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WINDOW_BYTES:  win_bytes  = 32'(cfg_data);
          CFG_SEQ_LIMIT:     stop_seq   = 32'(cfg_data);
          CFG_TIMEOUT_TICKS: resend_age = 32'(cfg_data[14:0]);
          default: ;
        endcase
      end
      // compare each header with the oldest one due
      if (out_valid && out_ready) begin
        got = {kind, seq, length, first_flag, end_flag, acked_point, transfer_done, last};
        if (headers_due.size() == 0) begin
          bad++;
          if (bad <= 10)
            $display("%0t: unexpected header kind %0d seq %0d len %0d acked %0d last %0d",
                     $time, kind, seq, length, acked_point, last);
        end else begin
          want = headers_due.pop_front();
          if (got !== want) begin
            bad++;
            if (bad <= 10) begin
              $display("%0t: header mismatch, expected kind %0d seq %0d len %0d first %0d",
                       $time, want.kind, want.seq, want.length, want.first_flag);
              $display("    end %0d acked %0d done %0d last %0d", want.end_flag,
                       want.acked_point, want.transfer_done, want.last);
              $display("  actual kind %0d seq %0d len %0d first %0d end %0d acked %0d",
                       got.kind, got.seq, got.length, got.first_flag, got.end_flag,
                       got.acked_point);
              $display("    done %0d last %0d", got.transfer_done, got.last);
            end
          end
        end
      end
      if (in_valid && in_ready)
        advance_window(opcode, seg_length, seg_first, seg_last, ack_seq);
    end
    pending    <= headers_due.size();
    mismatches <= bad;
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb
  import srsw_pkg::*;
();

  // the opcode that the block only answers with a status header
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = OP_OFFER;
  logic [8:0]  seg_length = '0;
  logic        seg_first = 1'b0;
  logic        seg_last = 1'b0;
  logic [15:0] ack_seq = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [15:0] seq;
  logic [8:0]  length;
  logic        first_flag;
  logic        end_flag;
  logic [15:0] acked_point;
  logic        transfer_done;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_WINDOW_BYTES;
  logic [15:0] cfg_data = '0;
  int          mismatches;
  int          pending;

  // no idling on either side while set
  bit          steady = 1'b0;
  // sequence numbers sent but not yet acknowledged by the stimulus
  logic [15:0] live_seqs[$];

  always #5 clk = ~clk;

  selective_repeat_sender_window u_top (.*);

  window_tracker u_chk (.*);

  // a header seen with both handshake lines high before an edge is taken at that edge
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready && kind == KIND_NEW)
      live_seqs.push_back(seq);
  end

  // receiver side: random stall before each header
  initial begin : take_headers
    int stall;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [8:0] len, input logic f,
                           input logic l, input logic [15:0] a);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    opcode     <= op;
    seg_length <= len;
    seg_first  <= f;
    seg_last   <= l;
    ack_seq    <= a;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold off until every header due has come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] w, input logic [15:0] lim,
                            input logic [14:0] tmo);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_WINDOW_BYTES;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_SEQ_LIMIT;
    cfg_data  <= lim;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_TIMEOUT_TICKS;
    cfg_data  <= {1'b0, tmo};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly an outstanding segment, a little out of order; now and then a stray number
  task automatic pick_ack(output logic [15:0] a);
    int idx;
    if (live_seqs.size() != 0 && $urandom_range(0, 9) != 0) begin
      idx = $urandom_range(0, (live_seqs.size() > 3) ? 3 : live_seqs.size() - 1);
      a = live_seqs[idx];
      if ($urandom_range(0, 7) != 0) live_seqs.delete(idx);
    end else begin
      a = 16'($urandom);
    end
  endtask

  task automatic random_traffic(input int n, input bit allow_end);
    int          pick;
    logic [8:0]  len;
    logic [15:0] a;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        case ($urandom_range(0, 9))
          0:       len = 9'd0;
          1:       len = 9'($urandom_range(460, 511));
          default: len = 9'($urandom_range(1, 511));
        endcase
        send_item(OP_OFFER, len, $urandom_range(0, 3) == 0,
                  allow_end && $urandom_range(0, 7) == 0, 16'($urandom));
      end else if (pick < 85) begin
        pick_ack(a);
        send_item(OP_ACK, 9'($urandom), 1'($urandom), 1'($urandom), a);
      end else if (pick < 97) begin
        send_item(OP_TICK, 9'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
      end else begin
        send_item(OP_SPARE, 9'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
      end
    end
  endtask

  // acknowledge everything still outstanding, oldest first
  task automatic ack_all();
    settle();
    while (live_seqs.size() != 0)
      send_item(OP_ACK, 9'($urandom), 1'($urandom), 1'($urandom), live_seqs.pop_front());
    settle();
  endtask

  initial begin : stimulus
    logic [15:0] a;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: low limit and timeout so restart and resend show up early
    set_config(16'd2500, 16'd1200, 15'd1);
    send_item(OP_SPARE, 9'd511, 1'b1, 1'b1, 16'hFFFF);
    send_item(OP_TICK, 9'd0, 1'b0, 1'b0, 16'h0000);
    send_item(OP_ACK, 9'd0, 1'b0, 1'b0, 16'hFFFF);
    send_item(OP_OFFER, 9'd0, 1'b1, 1'b0, 16'h0000);
    send_item(OP_OFFER, 9'd511, 1'b0, 1'b0, 16'hFFFF);
    send_item(OP_OFFER, 9'd500, 1'b0, 1'b0, 16'h0000);
    send_item(OP_OFFER, 9'd300, 1'b0, 1'b0, 16'h0000);
    // next number now past the limit
    send_item(OP_OFFER, 9'd1, 1'b0, 1'b0, 16'h0000);
    repeat (3) send_item(OP_TICK, 9'd0, 1'b0, 1'b0, 16'h0000);
    // out of order, then the zero-length segment, then a repeated number
    send_item(OP_ACK, 9'd0, 1'b0, 1'b0, 16'd500);
    send_item(OP_ACK, 9'd0, 1'b0, 1'b0, 16'd0);
    send_item(OP_ACK, 9'd0, 1'b0, 1'b0, 16'd0);
    send_item(OP_ACK, 9'd0, 1'b0, 1'b0, 16'd500);
    send_item(OP_TICK, 9'd0, 1'b0, 1'b0, 16'h0000);
    send_item(OP_ACK, 9'd0, 1'b0, 1'b0, 16'd1000);
    // all acknowledged past the limit: numbering restarts
    send_item(OP_OFFER, 9'd200, 1'b1, 1'b0, 16'h0000);
    send_item(OP_ACK, 9'd0, 1'b0, 1'b0, 16'd0);
    live_seqs.delete();

    // stop-and-wait with window and limit both set to one
    settle();
    set_config(16'd1, 16'd1, 15'd3);
    random_traffic(20, 1'b0);

    settle();
    set_config(16'd700, 16'd3000, 15'd2);
    random_traffic(25, 1'b0);

    // widest window, short numbering span
    settle();
    set_config(16'd65535, 16'd4000, 15'($urandom_range(2, 20)));
    steady = 1'b1;
    random_traffic(15, 1'b0);
    steady = 1'b0;
    random_traffic(20, 1'b0);

    // long run of large segments, acknowledged in order
    settle();
    set_config(16'd65535, 16'd65535, 15'd1000);
    for (int k = 0; k < 30; k++) begin
      send_item(OP_OFFER, 9'($urandom_range(440, 511)), k == 0, 1'b0, 16'($urandom));
      a = (live_seqs.size() != 0) ? live_seqs.pop_front() : 16'($urandom);
      send_item(OP_ACK, 9'($urandom), 1'($urandom), 1'($urandom), a);
      if (k % 16 == 15)
        send_item(OP_TICK, 9'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
    end
    ack_all();

    // longest timeout, a few ticks with segments outstanding
    set_config(16'd2500, 16'd60000, 15'd32767);
    send_item(OP_OFFER, 9'd300, 1'b1, 1'b0, 16'h0000);
    send_item(OP_OFFER, 9'd200, 1'b0, 1'b0, 16'h0000);
    steady = 1'b1;
    repeat (6) send_item(OP_TICK, 9'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
    steady = 1'b0;

    // end of transfer allowed from here on
    settle();
    set_config(16'd3000, 16'd50000, 15'd40);
    random_traffic(40, 1'b1);
    send_item(OP_OFFER, 9'd100, 1'b0, 1'b1, 16'h0000);
    random_traffic(8, 1'b1);
    ack_all();

    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
design/srsw_pkg.sv
design/srsw_cell.sv
design/selective_repeat_sender_window.sv
tb/window_tracker.sv
tb/tb.sv
